// ===== hdl/gsu_pkg.sv =====
// Shared types and constants for the glyph Scale2x/Scale3x upscaler.
`default_nettype none

package gsu_pkg;

  localparam int GLYPH_DIM = 8;
  localparam int SCALE_MAX = 3;
  localparam int COLS_MAX  = GLYPH_DIM * SCALE_MAX;
  localparam int SCALE_W   = 2;
  localparam int IDX_W     = 5;

  // scale_factor codes
  localparam logic [SCALE_W-1:0] SCALE_OFF   = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_COPY  = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_2X    = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_3X    = 2'd3;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_COPY;

  // glyph[cx][ry]: column cx, row ry
  typedef logic [GLYPH_DIM-1:0][GLYPH_DIM-1:0] glyph_t;
  // one pixel's output block, blk[dx][dy]
  typedef logic [SCALE_MAX-1:0][SCALE_MAX-1:0] cellblk_t;
  // all pixel blocks, cells[cx][ry]
  typedef cellblk_t [GLYPH_DIM-1:0][GLYPH_DIM-1:0] cells_t;
  // scaled columns, cols[j][r]
  typedef logic [COLS_MAX-1:0][COLS_MAX-1:0] cols_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    cells_t             cells;
  } cell_beat_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    cols_t              cols;
  } col_beat_t;

endpackage

`default_nettype wire

// ===== hdl/gsu_cell_stage.sv =====
// Pipeline stage that applies the Scale2x/Scale3x edge rules to every pixel.
`default_nettype none

module gsu_cell_stage (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire gsu_pkg::glyph_t         in_glyph,
  input  wire logic [1:0]              in_scale,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output gsu_pkg::cell_beat_t          out_beat
);
  import gsu_pkg::*;

  logic [GLYPH_DIM+1:0][GLYPH_DIM+1:0] pad;
  cells_t                              cells_next;
  logic                                valid;
  cell_beat_t                          beat;

  function automatic cellblk_t cell_rule(
    input logic ul, input logic up, input logic ur,
    input logic lf, input logic ctr, input logic rt,
    input logic dl, input logic dn, input logic dr,
    input logic [SCALE_W-1:0] s
  );
    cellblk_t c;
    logic     is_edge;
    c       = {(SCALE_MAX*SCALE_MAX){ctr}};
    is_edge = (up != dn) && (lf != rt);
    if (is_edge && s == SCALE_2X) begin
      c[0][0] = (lf == up) ? lf : ctr;
      c[1][0] = (up == rt) ? rt : ctr;
      c[0][1] = (lf == dn) ? lf : ctr;
      c[1][1] = (dn == rt) ? rt : ctr;
    end else if (is_edge && s == SCALE_3X) begin
      c[0][0] = (lf == up) ? lf : ctr;
      c[1][0] = ((lf == up && ctr != ur) || (up == rt && ctr != ul)) ? up : ctr;
      c[2][0] = (up == rt) ? rt : ctr;
      c[0][1] = ((lf == up && ctr != dl) || (lf == dn && ctr != ul)) ? lf : ctr;
      c[1][1] = ctr;
      c[2][1] = ((up == rt && ctr != dr) || (dn == rt && ctr != ur)) ? rt : ctr;
      c[0][2] = (lf == dn) ? lf : ctr;
      c[1][2] = ((lf == dn && ctr != dr) || (dn == rt && ctr != dl)) ? dn : ctr;
      c[2][2] = (dn == rt) ? rt : ctr;
    end
    return c;
  endfunction

  // surround the glyph with a ring of zero pixels
  always_comb begin
    pad = '0;
    for (int cx = 0; cx < GLYPH_DIM; cx++) begin
      for (int ry = 0; ry < GLYPH_DIM; ry++) begin
        pad[cx+1][ry+1] = in_glyph[cx][ry];
      end
    end
  end

  // evaluate each pixel from its 3x3 neighborhood
  for (genvar cx = 0; cx < GLYPH_DIM; cx++) begin : g_col
    for (genvar ry = 0; ry < GLYPH_DIM; ry++) begin : g_row
      assign cells_next[cx][ry] = cell_rule(
        pad[cx][ry],   pad[cx+1][ry],   pad[cx+2][ry],
        pad[cx][ry+1], pad[cx+1][ry+1], pad[cx+2][ry+1],
        pad[cx][ry+2], pad[cx+1][ry+2], pad[cx+2][ry+2],
        in_scale);
    end
  end

  assign in_stall = valid && out_stall;

  // advance when the stage is empty or its contents move on
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat.scale <= in_scale;
      beat.cells <= cells_next;
    end
  end

  assign out_valid = valid;
  assign out_beat  = beat;

endmodule

`default_nettype wire

// ===== hdl/gsu_pack_stage.sv =====
// Pipeline stage that places pixel blocks into scaled output columns.
`default_nettype none

module gsu_pack_stage (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire gsu_pkg::cell_beat_t     in_beat,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output gsu_pkg::col_beat_t           out_beat
);
  import gsu_pkg::*;

  cols_t     cols_next;
  logic      valid;
  col_beat_t beat;

  // each scaled bit has a fixed source for each scale; pick by scale
  for (genvar gj = 0; gj < COLS_MAX; gj++) begin : g_col
    for (genvar gb = 0; gb < COLS_MAX; gb++) begin : g_bit
      logic b1;
      logic b2;
      logic b3;
      if (gj < GLYPH_DIM && gb < GLYPH_DIM) begin : g_b1
        assign b1 = in_beat.cells[gj][gb][0][0];
      end else begin : g_b1z
        assign b1 = 1'b0;
      end
      if (gj < 2*GLYPH_DIM && gb < 2*GLYPH_DIM) begin : g_b2
        assign b2 = in_beat.cells[gj/2][gb/2][gj%2][gb%2];
      end else begin : g_b2z
        assign b2 = 1'b0;
      end
      assign b3 = in_beat.cells[gj/3][gb/3][gj%3][gb%3];

      always_comb begin
        unique case (in_beat.scale)
          SCALE_COPY: cols_next[gj][gb] = b1;
          SCALE_2X:   cols_next[gj][gb] = b2;
          SCALE_3X:   cols_next[gj][gb] = b3;
          default:    cols_next[gj][gb] = 1'b0;
        endcase
      end
    end
  end

  assign in_stall = valid && out_stall;

  // advance when the stage is empty or its contents move on
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat.scale <= in_beat.scale;
      beat.cols  <= cols_next;
    end
  end

  assign out_valid = valid;
  assign out_beat  = beat;

endmodule

`default_nettype wire

// ===== hdl/gsu_serializer.sv =====
// Output column buffer that sends one scaled column per transfer.
`default_nettype none

module gsu_serializer (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire gsu_pkg::col_beat_t      in_beat,
  output logic                         column_valid,
  input  wire logic                    column_stall,
  output logic [23:0]                  column_bits,
  output logic [4:0]                   column_index,
  output logic                         last
);
  import gsu_pkg::*;

  logic              busy;
  cols_t             cols;
  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  last_idx;
  logic              out_xfer;
  logic              at_last;
  logic              load;

  assign at_last  = (count == last_idx);
  assign out_xfer = busy && !column_stall;
  // take a new glyph once the buffer is empty or its final column leaves
  assign in_stall = busy && !(out_xfer && at_last);
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (out_xfer) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      count <= count + IDX_W'(1);
    end
  end

  // hold the glyph's columns and final index, 8 * scale - 1
  always_ff @(posedge clk) begin
    if (load) begin
      cols     <= in_beat.cols;
      last_idx <= {2'(in_beat.scale - SCALE_W'(1)), 3'b111};
    end
  end

  assign column_valid = busy;
  assign column_bits  = cols[count];
  assign column_index = count;
  assign last         = at_last;

endmodule

`default_nettype wire

// ===== hdl/glyph_scale2x_scale3x_upscaler_core.sv =====
// Top level of the glyph Scale2x/Scale3x upscaler.
//
//  channel   direction  handshake                  payload
//  glyph     in         glyph_valid/glyph_stall    col_0 .. col_7
//  column    out        column_valid/column_stall  column_bits, column_index, last
//  config    in         scale_we                   scale_data
//
// A glyph passes an input register, a cell stage and a pack stage and then
// the column buffer, which sends 8 * scale_factor columns at one per cycle
// while column_stall is low; that buffer paces the glyphs, taking the next one
// as its final column leaves, while up to three more glyphs wait in the stages.
// Synchronous reset empties all stages and sets scale_factor to 1.
// A stall holds every occupied stage; glyphs taken with scale_factor 0 are dropped.
`default_nettype none

module glyph_scale2x_scale3x_upscaler_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        scale_we,
  input  wire logic [1:0]  scale_data,
  input  wire logic        glyph_valid,
  output logic             glyph_stall,
  input  wire logic [7:0]  col_0,
  input  wire logic [7:0]  col_1,
  input  wire logic [7:0]  col_2,
  input  wire logic [7:0]  col_3,
  input  wire logic [7:0]  col_4,
  input  wire logic [7:0]  col_5,
  input  wire logic [7:0]  col_6,
  input  wire logic [7:0]  col_7,
  output logic             column_valid,
  input  wire logic        column_stall,
  output logic [23:0]      column_bits,
  output logic [4:0]       column_index,
  output logic             last
);
  import gsu_pkg::*;

  logic [SCALE_W-1:0] scale_factor;
  logic               in_valid;
  glyph_t             in_glyph;
  logic [SCALE_W-1:0] in_scale;
  logic               cell_stall;
  logic               cell_valid;
  cell_beat_t         cell_beat;
  logic               pack_stall;
  logic               pack_valid;
  col_beat_t          pack_beat;
  logic               ser_stall;

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RESET;
    end else if (scale_we) begin
      scale_factor <= scale_data;
    end
  end

  assign glyph_stall = in_valid && cell_stall;

  // capture the glyph with its scale; drop glyphs that make no columns
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!glyph_stall) begin
      in_valid <= glyph_valid && (scale_factor != SCALE_OFF);
    end
  end

  always_ff @(posedge clk) begin
    if (glyph_valid && !glyph_stall) begin
      in_glyph <= {col_7, col_6, col_5, col_4, col_3, col_2, col_1, col_0};
      in_scale <= scale_factor;
    end
  end

  gsu_cell_stage u_cell (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (cell_stall),
    .in_glyph  (in_glyph),
    .in_scale  (in_scale),
    .out_valid (cell_valid),
    .out_stall (pack_stall),
    .out_beat  (cell_beat)
  );

  gsu_pack_stage u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid),
    .in_stall  (pack_stall),
    .in_beat   (cell_beat),
    .out_valid (pack_valid),
    .out_stall (ser_stall),
    .out_beat  (pack_beat)
  );

  gsu_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pack_valid),
    .in_stall     (ser_stall),
    .in_beat      (pack_beat),
    .column_valid (column_valid),
    .column_stall (column_stall),
    .column_bits  (column_bits),
    .column_index (column_index),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== hdl/gsu_checker.sv =====
// Port-level checks for the upscaler, bound to the top level.
`default_nettype none

module gsu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        column_valid,
  input wire logic        column_stall,
  input wire logic [23:0] column_bits,
  input wire logic [4:0]  column_index,
  input wire logic        last
);

  // a stalled column holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    column_valid && column_stall |=> column_valid && $stable(column_bits)
      && $stable(column_index) && $stable(last))
    else $error("stalled column changed");

  // columns of one glyph come in order
  a_step: assert property (@(posedge clk) disable iff (rst)
    column_valid && !column_stall && !last |=>
      column_valid && column_index == $past(column_index) + 5'd1)
    else $error("column index skipped");

  // a new glyph starts at column zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    column_valid && !column_stall && last |=> !column_valid || column_index == 5'd0)
    else $error("glyph did not start at column zero");

  // the final column closes a glyph of 8, 16 or 24 columns
  a_len: assert property (@(posedge clk) disable iff (rst)
    column_valid && last |->
      (column_index == 5'd7 || column_index == 5'd15 || column_index == 5'd23))
    else $error("glyph length is wrong");

endmodule

bind glyph_scale2x_scale3x_upscaler_core gsu_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .column_valid (column_valid),
  .column_stall (column_stall),
  .column_bits  (column_bits),
  .column_index (column_index),
  .last         (last)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the glyph Scale2x/Scale3x upscaler core.
module tb;
  import gsu_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 200000;

  // One scaled column as the core sends it
  typedef struct packed {
    logic [COLS_MAX-1:0] bits;
    logic [IDX_W-1:0]    index;
    logic                last;
  } scaled_col_t;

  // How a stimulus row gets its expected columns
  typedef enum logic [1:0] {EXP_MODEL, EXP_BLANK, EXP_COPY} row_check_e;

  typedef struct {
    logic [SCALE_W-1:0] scale;
    glyph_t             glyph;
    row_check_e         chk;
  } glyph_row_t;

  localparam int N_DIRECTED = 22;

  // Glyph literals hold col_7 in the top byte and col_0 in the bottom byte
  glyph_row_t directed_glyphs [N_DIRECTED] = '{
    '{SCALE_COPY, 64'h0000000000000000, EXP_BLANK},
    '{SCALE_COPY, 64'hFFFFFFFFFFFFFFFF, EXP_COPY},
    '{SCALE_COPY, 64'h55AA55AA55AA55AA, EXP_COPY},
    '{SCALE_COPY, 64'h0000000000000001, EXP_COPY},
    '{SCALE_COPY, 64'h8000000000000000, EXP_COPY},
    '{SCALE_3X,   64'h0000000000000000, EXP_BLANK},
    '{SCALE_3X,   64'hFFFFFFFFFFFFFFFF, EXP_MODEL},
    '{SCALE_3X,   64'h0000000000000001, EXP_MODEL},
    '{SCALE_3X,   64'h0000000008000000, EXP_MODEL},
    '{SCALE_3X,   64'h8040201008040201, EXP_MODEL},
    '{SCALE_3X,   64'h0102040810204080, EXP_MODEL},
    '{SCALE_3X,   64'h55AA55AA55AA55AA, EXP_MODEL},
    '{SCALE_3X,   64'hFF818181818181FF, EXP_MODEL},
    '{SCALE_3X,   64'h0000007C1211127C, EXP_MODEL},
    '{SCALE_2X,   64'h0000000000000000, EXP_BLANK},
    '{SCALE_2X,   64'hFFFFFFFFFFFFFFFF, EXP_MODEL},
    '{SCALE_2X,   64'h8040201008040201, EXP_MODEL},
    '{SCALE_2X,   64'h55AA55AA55AA55AA, EXP_MODEL},
    '{SCALE_2X,   64'h0000007C1211127C, EXP_MODEL},
    '{SCALE_2X,   64'h8000000000000000, EXP_MODEL},
    '{SCALE_OFF,  64'hFFFFFFFFFFFFFFFF, EXP_MODEL},
    '{SCALE_OFF,  64'h0000007C1211127C, EXP_MODEL}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        scale_we = 1'b0;
  logic [1:0]  scale_data = '0;
  logic        glyph_valid = 1'b0;
  logic        glyph_stall;
  logic [7:0]  col_0 = '0, col_1 = '0, col_2 = '0, col_3 = '0;
  logic [7:0]  col_4 = '0, col_5 = '0, col_6 = '0, col_7 = '0;
  logic        column_valid;
  logic        column_stall = 1'b0;
  logic [23:0] column_bits;
  logic [4:0]  column_index;
  logic        last;

  scaled_col_t        expected_columns [$];
  logic [SCALE_W-1:0] cur_scale = SCALE_RESET;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  logic               hold_go = 1'b0;
  logic               hold_off = 1'b0;
  int                 n_errors = 0;
  int                 n_glyphs = 0;
  int                 n_columns = 0;
  int                 n_input_stalls = 0;

  glyph_scale2x_scale3x_upscaler_core DUT (
    .clk          (clk),
    .rst          (rst),
    .scale_we     (scale_we),
    .scale_data   (scale_data),
    .glyph_valid  (glyph_valid),
    .glyph_stall  (glyph_stall),
    .col_0        (col_0),
    .col_1        (col_1),
    .col_2        (col_2),
    .col_3        (col_3),
    .col_4        (col_4),
    .col_5        (col_5),
    .col_6        (col_6),
    .col_7        (col_7),
    .column_valid (column_valid),
    .column_stall (column_stall),
    .column_bits  (column_bits),
    .column_index (column_index),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixel lookup; anything outside the glyph reads as background
  function automatic logic glyph_px(glyph_t g, int cx, int ry);
    if (cx < 0 || cx >= GLYPH_DIM || ry < 0 || ry >= GLYPH_DIM) return 1'b0;
    return g[cx][ry];
  endfunction

  // Scale one glyph with the edge rules and queue its columns in send order
  function automatic void scale_glyph(glyph_t g, logic [SCALE_W-1:0] s);
    logic [COLS_MAX-1:0] cols [COLS_MAX];
    cellblk_t blk;
    logic ul, up, ur, lf, ctr, rt, dl, dn, dr;
    logic blend;
    int sf, n;
    sf = s;
    n = GLYPH_DIM * sf;
    for (int j = 0; j < COLS_MAX; j++) cols[j] = '0;
    for (int cx = 0; cx < GLYPH_DIM; cx++) begin
      for (int ry = 0; ry < GLYPH_DIM; ry++) begin
        ul  = glyph_px(g, cx - 1, ry - 1);
        up  = glyph_px(g, cx,     ry - 1);
        ur  = glyph_px(g, cx + 1, ry - 1);
        lf  = glyph_px(g, cx - 1, ry);
        ctr = glyph_px(g, cx,     ry);
        rt  = glyph_px(g, cx + 1, ry);
        dl  = glyph_px(g, cx - 1, ry + 1);
        dn  = glyph_px(g, cx,     ry + 1);
        dr  = glyph_px(g, cx + 1, ry + 1);
        // A flat run in either direction keeps the pixel as a plain block
        blend = (up != dn) && (lf != rt);
        blk = {(SCALE_MAX * SCALE_MAX){ctr}};
        if (blend && s == SCALE_2X) begin
          blk[0][0] = (lf == up) ? lf : ctr;
          blk[1][0] = (up == rt) ? rt : ctr;
          blk[0][1] = (lf == dn) ? lf : ctr;
          blk[1][1] = (dn == rt) ? rt : ctr;
        end else if (blend && s == SCALE_3X) begin
          blk[0][0] = (lf == up) ? lf : ctr;
          blk[1][0] = ((lf == up && ctr != ur) || (up == rt && ctr != ul)) ? up : ctr;
          blk[2][0] = (up == rt) ? rt : ctr;
          blk[0][1] = ((lf == up && ctr != dl) || (lf == dn && ctr != ul)) ? lf : ctr;
          blk[1][1] = ctr;
          blk[2][1] = ((up == rt && ctr != dr) || (dn == rt && ctr != ur)) ? rt : ctr;
          blk[0][2] = (lf == dn) ? lf : ctr;
          blk[1][2] = ((lf == dn && ctr != dr) || (dn == rt && ctr != dl)) ? dn : ctr;
          blk[2][2] = (dn == rt) ? rt : ctr;
        end
        for (int dx = 0; dx < sf; dx++)
          for (int dy = 0; dy < sf; dy++)
            cols[sf * cx + dx][sf * ry + dy] = blk[dx][dy];
      end
    end
    for (int j = 0; j < n; j++)
      expected_columns.push_back('{bits: cols[j], index: IDX_W'(j), last: (j == n - 1)});
  endfunction

  // Random glyph: plain, sparse or dense pixels
  function automatic glyph_t rand_glyph();
    glyph_t g;
    int mode;
    mode = $urandom_range(2, 0);
    for (int cx = 0; cx < GLYPH_DIM; cx++) begin
      case (mode)
        0:       g[cx] = 8'($urandom);
        1:       g[cx] = 8'($urandom & $urandom);
        default: g[cx] = 8'($urandom | $urandom);
      endcase
    end
    return g;
  endfunction

  // Offer one glyph after a random gap, hold it until the transfer,
  // then queue what it should produce
  task automatic send_glyph(input glyph_t g, input row_check_e chk);
    int n;
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      glyph_valid <= 1'b0;
      @(posedge clk);
    end
    glyph_valid <= 1'b1;
    col_0 <= g[0];
    col_1 <= g[1];
    col_2 <= g[2];
    col_3 <= g[3];
    col_4 <= g[4];
    col_5 <= g[5];
    col_6 <= g[6];
    col_7 <= g[7];
    @(posedge clk);
    while (glyph_stall) @(posedge clk);
    n_glyphs++;
    n = GLYPH_DIM * cur_scale;
    case (chk)
      EXP_BLANK:
        for (int j = 0; j < n; j++)
          expected_columns.push_back('{bits: '0, index: IDX_W'(j), last: (j == n - 1)});
      EXP_COPY:
        for (int j = 0; j < GLYPH_DIM; j++)
          expected_columns.push_back('{bits: COLS_MAX'(g[j]), index: IDX_W'(j),
                                       last: (j == GLYPH_DIM - 1)});
      default:
        scale_glyph(g, cur_scale);
    endcase
  endtask

  // Drop valid, let every expected column arrive, then allow for glyphs
  // that are still passing through the stages without producing output
  task automatic settle();
    glyph_valid <= 1'b0;
    stall_pct = 0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_W-1:0] s);
    settle();
    scale_we   <= 1'b1;
    scale_data <= s;
    @(posedge clk);
    scale_we  <= 1'b0;
    cur_scale = s;
  endtask

  task automatic run_phase(input logic [SCALE_W-1:0] s, input int gap, input int stall,
                           input int n_items, input logic hold);
    set_scale(s);
    gap_pct   = gap;
    stall_pct = stall;
    if (hold) hold_go = 1'b1;
    repeat (n_items) send_glyph(rand_glyph(), EXP_MODEL);
  endtask

  // Receiver stall: random per cycle, forced high during the hold-off
  always @(posedge clk) begin
    column_stall <= hold_off || ($urandom_range(99, 0) < stall_pct);
  end

  // Long receiver hold-off so the stages fill and the input backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Compare each column transfer against the oldest expectation
  always @(posedge clk) begin : check_column
    scaled_col_t want;
    if (!rst && glyph_valid && glyph_stall) n_input_stalls++;
    if (!rst && column_valid && !column_stall) begin
      n_columns++;
      if (expected_columns.size() == 0) begin
        $error("column with nothing expected: bits %h index %0d last %0b",
               column_bits, column_index, last);
        n_errors++;
      end else begin
        want = expected_columns.pop_front();
        if (column_bits !== want.bits) begin
          $error("column_bits: expected %h, got %h", want.bits, column_bits);
          n_errors++;
        end
        if (column_index !== want.index) begin
          $error("column_index: expected %0d, got %0d", want.index, column_index);
          n_errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, starting at the reset scale
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_glyphs[i].scale != cur_scale) set_scale(directed_glyphs[i].scale);
      send_glyph(directed_glyphs[i].glyph, directed_glyphs[i].chk);
    end

    // Random glyphs across scales and idling patterns
    run_phase(SCALE_3X,   0,  0,  20, 1'b0);
    run_phase(SCALE_2X,   61, 0,  20, 1'b0);
    run_phase(SCALE_COPY, 0,  61, 20, 1'b0);
    run_phase(SCALE_OFF,  10, 10, 8,  1'b0);
    run_phase(SCALE_3X,   10, 10, 20, 1'b0);
    run_phase(SCALE_3X,   0,  0,  20, 1'b1);
    run_phase(SCALE_2X,   61, 61, 20, 1'b0);
    settle();

    $display("Run covered %0d glyphs and %0d scaled columns at scale factors 0 to 3,",
             n_glyphs, n_columns);
    $display("with idle and stall patterns on both sides and %0d cycles of input backpressure.",
             n_input_stalls);
    if (n_errors == 0 && expected_columns.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
